// File: sv/csfp_pkg.sv
// shared types and constants for the camera status frame parser
package csfp_pkg;

   // frame markers
   localparam logic [7:0] HDR_BYTE       = 8'hAA;
   localparam logic [7:0] FRAME_LEN_BASE = 8'h0A;
   localparam logic [7:0] FRAME_LEN_ZOOM = 8'h0B;
   localparam logic [7:0] FRAME_LEN_LAMP = 8'h0C;
   localparam logic [7:0] FRAME_LEN_ANGL = 8'h10;

   // packet byte positions
   localparam logic [4:0] POS_FIRST    = 5'd2;
   localparam logic [4:0] POS_FOV_HI   = 5'd2;
   localparam logic [4:0] POS_FOV_LO   = 5'd3;
   localparam logic [4:0] POS_FOCUS_HI = 5'd4;
   localparam logic [4:0] POS_FOCUS_LO = 5'd5;
   localparam logic [4:0] POS_STAT_LO  = 5'd6;
   localparam logic [4:0] POS_STAT_HI  = 5'd7;
   localparam logic [4:0] POS_SENSOR   = 5'd8;
   localparam logic [4:0] POS_VERSION  = 5'd9;
   localparam logic [4:0] POS_EXTRA1   = 5'd10;
   localparam logic [4:0] POS_EXTRA2   = 5'd11;
   localparam logic [4:0] POS_ROLL_HI  = 5'd12;
   localparam logic [4:0] POS_ROLL_LO  = 5'd13;
   localparam logic [4:0] POS_PITCH_HI = 5'd14;
   localparam logic [4:0] POS_PITCH_LO = 5'd15;

   // focus mode codes
   localparam logic [1:0] FMODE_MANUAL = 2'd1;
   localparam logic [1:0] FMODE_AUTO   = 2'd2;

   // configuration register indexes
   localparam logic CSR_FOV_EN   = 1'b0;
   localparam logic CSR_FOCUS_EN = 1'b1;

   localparam int RSP_BITS  = 108;
   localparam int RSP_BYTES = (RSP_BITS + 7) / 8;
   localparam int RSP_WIDTH = RSP_BYTES * 8;

   typedef enum logic [1:0] {
      PH_HUNT    = 2'd0,
      PH_LEN     = 2'd1,
      PH_PAYLOAD = 2'd2
   } phase_type;

   typedef struct packed {
      logic fov_en;
      logic focus_en;
   } enable_type;

   // first member sits in the highest bits
   typedef struct packed {
      logic [15:0] pitch_hundredths;
      logic [15:0] roll_hundredths;
      logic [1:0]  image_type;
      logic        illuminator_on;
      logic        digital_zoom_on;
      logic [6:0]  picture_levels;
      logic [7:0]  board_version;
      logic [7:0]  sensor_code;
      logic        focus_auto;
      logic [15:0] status_word;
      logic [15:0] focus_position;
      logic [15:0] fov_position;
   } status_type;

   localparam status_type STATUS_RESET = '{
      pitch_hundredths: 16'h0000, roll_hundredths: 16'h0000, image_type: 2'b00,
      illuminator_on: 1'b0, digital_zoom_on: 1'b0, picture_levels: 7'h00,
      board_version: 8'h00, sensor_code: 8'h00, focus_auto: 1'b1,
      status_word: 16'h0000, focus_position: 16'h0000, fov_position: 16'h0000};

endpackage

// File: sv/csfp_frame_decode.sv
// frame sync, byte position tracking and held status update
module csfp_frame_decode (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            rx_byte,
   input  csfp_pkg::enable_type  enable,
   output logic                  frame_done,
   output csfp_pkg::status_type  snapshot
);

   csfp_pkg::phase_type  phase_ff, phase_in;
   logic [4:0]           pos_ff, pos_in;
   logic [4:0]           total_ff, total_in;
   logic [7:0]           temp_ff, temp_in;
   csfp_pkg::status_type hold_ff, hold_in;
   logic                 len_ok;
   logic                 is_zoom, is_lamp, is_angl;
   logic                 done;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= csfp_pkg::PH_HUNT;
         pos_ff   <= '0;
         total_ff <= '0;
         temp_ff  <= '0;
         hold_ff  <= csfp_pkg::STATUS_RESET;
      end else if (accept) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         total_ff <= total_in;
         temp_ff  <= temp_in;
         hold_ff  <= hold_in;
      end
   end

   assign len_ok = (rx_byte == csfp_pkg::FRAME_LEN_BASE) || (rx_byte == csfp_pkg::FRAME_LEN_ZOOM)
                || (rx_byte == csfp_pkg::FRAME_LEN_LAMP) || (rx_byte == csfp_pkg::FRAME_LEN_ANGL);
   assign is_zoom = ({3'b000, total_ff} == csfp_pkg::FRAME_LEN_ZOOM);
   assign is_lamp = ({3'b000, total_ff} == csfp_pkg::FRAME_LEN_LAMP);
   assign is_angl = ({3'b000, total_ff} == csfp_pkg::FRAME_LEN_ANGL);

   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      total_in = total_ff;
      temp_in  = temp_ff;
      hold_in  = hold_ff;
      done     = 1'b0;
      case (phase_ff)
         csfp_pkg::PH_LEN: begin
            if (len_ok) begin
               total_in = rx_byte[4:0];
               pos_in   = csfp_pkg::POS_FIRST;
               phase_in = csfp_pkg::PH_PAYLOAD;
            end else begin
               phase_in = csfp_pkg::PH_HUNT;
            end
         end
         csfp_pkg::PH_PAYLOAD: begin
            case (pos_ff)
               csfp_pkg::POS_FOV_HI, csfp_pkg::POS_FOCUS_HI, csfp_pkg::POS_STAT_LO,
               csfp_pkg::POS_ROLL_HI, csfp_pkg::POS_PITCH_HI: begin
                  temp_in = rx_byte;
               end
               csfp_pkg::POS_FOV_LO: begin
                  if (enable.fov_en) hold_in.fov_position = {temp_ff, rx_byte};
               end
               csfp_pkg::POS_FOCUS_LO: begin
                  if (enable.focus_en) hold_in.focus_position = {temp_ff, rx_byte};
               end
               csfp_pkg::POS_STAT_HI: begin
                  // status word arrives little-endian
                  hold_in.status_word = {rx_byte, temp_ff};
                  if (temp_ff[5:4] == csfp_pkg::FMODE_AUTO) begin
                     hold_in.focus_auto = 1'b1;
                  end else if (temp_ff[5:4] == csfp_pkg::FMODE_MANUAL) begin
                     hold_in.focus_auto = 1'b0;
                  end
               end
               csfp_pkg::POS_SENSOR: begin
                  hold_in.sensor_code = rx_byte;
               end
               csfp_pkg::POS_VERSION: begin
                  hold_in.board_version = rx_byte;
               end
               csfp_pkg::POS_EXTRA1: begin
                  if (is_zoom || is_lamp) hold_in.picture_levels = rx_byte[6:0];
                  if (is_zoom) hold_in.digital_zoom_on = rx_byte[7];
                  if (is_lamp) hold_in.illuminator_on = rx_byte[7];
               end
               csfp_pkg::POS_EXTRA2: begin
                  if (is_lamp) begin
                     hold_in.image_type      = rx_byte[1:0];
                     hold_in.digital_zoom_on = rx_byte[2];
                  end
               end
               csfp_pkg::POS_ROLL_LO: begin
                  if (is_angl) hold_in.roll_hundredths = {temp_ff, rx_byte};
               end
               csfp_pkg::POS_PITCH_LO: begin
                  if (is_angl) hold_in.pitch_hundredths = {temp_ff, rx_byte};
               end
               default: begin
               end
            endcase
            // payload runs over packet bytes 2 .. total+1
            if (pos_ff < 5'(total_ff + 5'd1)) begin
               pos_in = 5'(pos_ff + 5'd1);
            end else begin
               done     = 1'b1;
               phase_in = csfp_pkg::PH_HUNT;
               pos_in   = '0;
            end
         end
         default: begin
            phase_in = (rx_byte == csfp_pkg::HDR_BYTE) ? csfp_pkg::PH_LEN : csfp_pkg::PH_HUNT;
         end
      endcase
   end

   assign frame_done = done;
   assign snapshot   = hold_in;

endmodule

// File: sv/camera_status_frame_parser_core.sv
// camera status frame parser top level: handshake, config and result register
//
// channel  | ports        | width | carries
// ---------+--------------+-------+------------------------------------------
// req      | req_t*       | 8     | one received serial byte per transfer
// rsp      | rsp_t*       | 112   | status snapshot, one per completed frame
// csr      | csr_*        | 1     | fov / focus update enables, write only
//
// one byte per cycle while no held result stalls; each byte is decoded when
// accepted, and a finished frame lands in the result register on that edge
// the result register is the only storage between the two sides, so a byte is
// taken while a result waits as long as the sink takes it in that cycle
// a held result blocks further bytes only while rsp_tready is low
// synchronous reset: hunting for header, enables set, status cleared except
// focus_auto, which comes up as auto
module camera_status_frame_parser_core (
   input  logic                           clock,
   input  logic                           reset,
   // byte input
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // rx_byte[7:0]
   // result output
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // fov_position[15:0] focus_position[31:16] status_word[47:32] focus_auto[48]
   // sensor_code[56:49] board_version[64:57] picture_levels[71:65]
   // digital_zoom_on[72] illuminator_on[73] image_type[75:74]
   // roll_hundredths[91:76] pitch_hundredths[107:92] zero[111:108]
   output logic [csfp_pkg::RSP_WIDTH-1:0] rsp_tdata,
   // configuration writes
   input  logic                           csr_we,
   input  logic                           csr_index,
   input  logic                           csr_wdata
);

   csfp_pkg::enable_type enable_ff;
   csfp_pkg::status_type rsp_data_ff;
   csfp_pkg::status_type snapshot;
   logic                 rsp_valid_ff;
   logic                 accept;
   logic                 frame_done;

   // enables, sampled by the decoder when the low byte of each value lands
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= '{fov_en: 1'b1, focus_en: 1'b1};
      end else if (csr_we) begin
         case (csr_index)
            csfp_pkg::CSR_FOV_EN:   enable_ff.fov_en   <= csr_wdata;
            csfp_pkg::CSR_FOCUS_EN: enable_ff.focus_en <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // take a byte whenever the result slot is empty or draining this cycle
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   csfp_frame_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .rx_byte    (req_tdata),
      .enable     (enable_ff),
      .frame_done (frame_done),
      .snapshot   (snapshot)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept && frame_done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && frame_done) begin
         rsp_data_ff <= snapshot;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(csfp_pkg::RSP_WIDTH - csfp_pkg::RSP_BITS){1'b0}}, rsp_data_ff};

endmodule

// File: sv/csfp_checker.sv
// port level checks for the camera status frame parser, with bind
module csfp_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [csfp_pkg::RSP_WIDTH-1:0] rsp_tdata
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // input side stalls only behind a held result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled with no result held");

   // a fresh result needs a byte transfer on the edge before
   a_fresh_source: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && $past(!rsp_tvalid || rsp_tready) |-> $past(req_tvalid && req_tready))
      else $error("result appeared without an input transfer");

   // padding above the packed fields stays zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[csfp_pkg::RSP_WIDTH-1:csfp_pkg::RSP_BITS] == '0)
      else $error("nonzero padding in result");

endmodule

bind camera_status_frame_parser_core csfp_checker u_csfp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
